@@ src/bare_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the button auto-repeat engine
// no dependencies; used by every module of the block except bare_ram

package bare_pkg;

	// table geometry
	localparam int NUM_PLAYERS = 2;
	localparam int NUM_BUTTONS = 32;
	localparam int TABLE_SIZE  = NUM_PLAYERS * NUM_BUTTONS;
	localparam int IDX_W       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int PLY_CW      = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;
	localparam int BTN_CW      = $clog2(NUM_BUTTONS);

	// field and register widths
	localparam int ACTION_W = 2;
	localparam int PLAYER_W = 1;
	localparam int BUTTON_W = 5;
	localparam int COUNT_W  = 16;
	localparam int CFG_IDX_W = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// reset values of the registers
	localparam logic [COUNT_W-1:0] DELAY_RESET    = 16'd30;
	localparam logic [COUNT_W-1:0] INTERVAL_RESET = 16'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 8'd1;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [PLAYER_W-1:0] player;
		logic [BUTTON_W-1:0] button;
	} in_word_t;

	typedef struct packed {
		logic [PLAYER_W-1:0] rep_player;
		logic [BUTTON_W-1:0] rep_button;
		logic                last_of_tick;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept_in;
		logic start_sweep;
		logic eval;
		logic flush;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic commit;
		logic last_entry;
		logic flush_done;
	} dp_status_t;

endpackage

@@ src/button_auto_repeat_engine_unit.sv @@
`timescale 1ns / 1ps
// top level of the button auto-repeat engine
// depends on bare_pkg, bare_ctrl, bare_dp, bare_ram

// A press or release word is taken only while the block is idle. A tick word
// walks the whole player/button table, one entry per cycle through the entry
// ram that holds each repeat flag and tick count (reading the next entry while
// writing back the current one), except while a repeat event waits because the
// pending event and the stalled output register are both full; the final event
// then waits on a stalled output before the block takes input again.
// Repeat events leave in ascending player, then button order, the last one
// of a tick carrying last_of_tick. The registers are always ready and are
// meant to be written while the block is idle.

module button_auto_repeat_engine_unit import bare_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	bare_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_data (in_data),
		.in_stall(in_stall),
		.cmd     (cmd),
		.status  (status)
	);

	// entry table and event path
	bare_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

@@ src/bare_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module bare_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/bare_ctrl.sv @@
`timescale 1ns / 1ps
// controller of the auto-repeat engine: idle, table sweep and final flush
// depends on bare_pkg

module bare_ctrl import bare_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_word_t   in_data,
	output logic       in_stall,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_data.action == ACT_TICK) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (status.commit && status.last_entry) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (status.flush_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall        = 1'b1;
		cmd             = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.accept_in   = in_valid;
				cmd.start_sweep = in_valid && in_data.action == ACT_TICK;
			end
			ST_SWEEP: begin
				cmd.eval = 1'b1;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ src/bare_dp.sv @@
`timescale 1ns / 1ps
// datapath of the auto-repeat engine: armed flags, entry ram (repeat flag and tick count),
// sweep counters, pending event and output register; depends on bare_pkg, bare_ram

module bare_dp import bare_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_word_t             in_data,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data
);

	logic [COUNT_W-1:0]    delay_q, interval_q;
	logic [TABLE_SIZE-1:0] armed_q;
	logic                  armed_rd_q;
	logic [IDX_W-1:0]      idx_q;
	logic [PLY_CW-1:0]     ply_q;
	logic [BTN_CW-1:0]     btn_q;
	logic                  pend_valid_q;
	out_word_t             pend_q;
	logic                  out_valid_q;
	out_word_t             out_q;

	logic [COUNT_W:0]   rd_entry;
	logic [COUNT_W-1:0] rd_count, inc_count, new_count;
	logic               rd_rep;
	logic               fire, new_rep, entry_armed, out_free, commit;
	logic               in_ok;
	logic [IDX_W-1:0]   in_idx;
	logic               ram_wr_en, ram_rd_en;
	logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
	logic [COUNT_W:0]   ram_wr_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DELAY_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == REG_INITIAL_DELAY) begin
				delay_q <= cfg_data;
			end else if (cfg_index == REG_REPEAT_INTERVAL) begin
				interval_q <= cfg_data;
			end
		end
	end

	// press and release decode
	always_comb begin
		in_ok  = in_data.button != '0
			&& 32'(in_data.player) < NUM_PLAYERS
			&& 32'(in_data.button) < NUM_BUTTONS;
		in_idx = IDX_W'(32'(in_data.player) * NUM_BUTTONS + 32'(in_data.button));
	end

	// entry evaluation on the repeat flag and count read back from the ram
	always_comb begin
		rd_count    = rd_entry[COUNT_W-1:0];
		rd_rep      = rd_entry[COUNT_W];
		entry_armed = armed_rd_q;
		inc_count   = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
		fire        = 1'b0;
		new_rep     = rd_rep;
		new_count   = inc_count;
		if (!rd_rep) begin
			if (inc_count >= delay_q) begin
				fire      = 1'b1;
				new_rep   = 1'b1;
				new_count = '0;
			end
		end else if (inc_count >= interval_q) begin
			fire      = 1'b1;
			new_count = '0;
		end
		fire     = fire && entry_armed;
		out_free = !out_valid_q || !out_stall;
		commit   = cmd.eval && !(fire && pend_valid_q && !out_free);
	end

	// ram port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = {new_rep, new_count};
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_q + 1'b1;
		if (cmd.accept_in && in_data.action == ACT_PRESS && in_ok) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = in_idx;
			ram_wr_data = '0;
		end else if (commit && entry_armed) begin
			ram_wr_en = 1'b1;
		end
		if (cmd.start_sweep) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = '0;
		end else if (commit) begin
			ram_rd_en = 1'b1;
		end
	end

	bare_ram #(
		.WIDTH(COUNT_W + 1),
		.DEPTH(TABLE_SIZE)
	) u_count_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(rd_entry)
	);

	// armed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (cmd.accept_in && in_ok && in_data.action == ACT_PRESS) begin
			armed_q[in_idx] <= 1'b1;
		end else if (cmd.accept_in && in_ok && in_data.action == ACT_RELEASE) begin
			armed_q[in_idx] <= 1'b0;
		end
	end

	// armed flag read alongside the ram entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_rd_q <= 1'b0;
		end else if (ram_rd_en) begin
			armed_rd_q <= armed_q[ram_rd_addr];
		end
	end

	// sweep position, player then button order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ply_q <= '0;
			btn_q <= '0;
		end else if (cmd.start_sweep) begin
			idx_q <= '0;
			ply_q <= '0;
			btn_q <= '0;
		end else if (commit) begin
			idx_q <= idx_q + 1'b1;
			if (32'(btn_q) == NUM_BUTTONS - 1) begin
				btn_q <= '0;
				ply_q <= ply_q + 1'b1;
			end else begin
				btn_q <= btn_q + 1'b1;
			end
		end
	end

	// pending event, held back until the next one shows whether it was last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (commit && fire) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.flush && out_free) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && fire) begin
			pend_q.rep_player   <= PLAYER_W'(ply_q);
			pend_q.rep_button   <= BUTTON_W'(btn_q);
			pend_q.last_of_tick <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((commit && fire && pend_valid_q)
				|| (cmd.flush && pend_valid_q && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && fire && pend_valid_q) begin
			out_q <= pend_q;
		end else if (cmd.flush && pend_valid_q && out_free) begin
			out_q              <= pend_q;
			out_q.last_of_tick <= 1'b1;
		end
	end

	// status to controller
	always_comb begin
		status.commit     = commit;
		status.last_entry = 32'(idx_q) == TABLE_SIZE - 1;
		status.flush_done = !pend_valid_q || out_free;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
